/* rtl/rc5_pkg.sv */
// Shared constants, codes and rotate helpers for the RC5-32/12/16 cipher block.
// No dependencies; the other files of the block import this package, all but rc5_ram.
package rc5_pkg;

    localparam int ROUNDS      = 12;
    localparam int ROWS        = ROUNDS + 1;
    localparam int TABLE_WORDS = 2 * ROWS;
    localparam int KEY_WORDS   = 4;
    localparam int MIX_STEPS   = 3 * TABLE_WORDS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int TI_W   = $clog2(TABLE_WORDS);
    localparam int KI_W   = $clog2(KEY_WORDS);
    localparam int STEP_W = $clog2(MIX_STEPS);

    localparam logic [31:0] RESET_MAGIC_P = 32'h00d2_20e3;
    localparam logic [31:0] RESET_MAGIC_Q = 32'h0063_438b;

    typedef enum logic [1:0]
    {
        OP_ENCRYPT = 2'd0,
        OP_DECRYPT = 2'd1,
        OP_EXPAND  = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0]
    {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_HIGH = 2'd1,
        REG_MAGIC_P  = 2'd2,
        REG_MAGIC_Q  = 2'd3
    } reg_index_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] tmp;
        tmp = {x, x} << n;
        return tmp[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] tmp;
        tmp = {x, x} >> n;
        return tmp[31:0];
    endfunction

endpackage

/* rtl/rc5_if.sv */
// Handshake channel interfaces of the RC5 block: block request, block result, register write.
// Depends on rc5_pkg for the register index type.
interface rc5_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] in_word_a;
    logic [31:0] in_word_b;

    modport source (output valid, output opcode, output in_word_a, output in_word_b,
                    input ready);
    modport sink   (input valid, input opcode, input in_word_a, input in_word_b,
                    output ready);
endinterface

interface rc5_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word_a;
    logic [31:0] out_word_b;

    modport source (output valid, output out_word_a, output out_word_b, input ready);
    modport sink   (input valid, input out_word_a, input out_word_b, output ready);
endinterface

interface rc5_cfg_if
    import rc5_pkg::*;
;
    logic        valid;
    logic        ready;
    reg_index_t  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/rc5_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rc5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 13,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rc5_block_cipher.sv */
// RC5-32/12/16 block cipher top level: control sequencer, round-key memories, result register.
// Depends on rc5_pkg, the rc5 channel interfaces and rc5_ram.

// The round-key table lives in two 13-word memories, one for the even and one for the odd
// table words, so one round reads both of its keys in a single access. For encrypt and
// decrypt, CIPH_LD prefetches the first key pair, CIPH_RUN performs the key addition and
// the 12 rounds (for decrypt, the rounds in reverse and then the key subtraction), one
// round per cycle, and DONE hands the result over once the result register is free. Key
// expansion runs FILL, which writes all 13 rows as even/odd word pairs, then MIX_RD as a
// prefetch, then 78 mixing steps that each pass through MIX_A (table word update) and MIX_B
// (key word update), and DONE for the handover. One request is processed at a time; a new
// request is taken as soon as the previous result has moved into the result register, even
// while that result still waits. The table reads as zero after reset until the first key expansion fills it.
module rc5_block_cipher
    import rc5_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    rc5_req_if.sink   request,
    rc5_res_if.source result,
    rc5_cfg_if.sink   cfg
);

    typedef enum logic [7:0]
    {
        ST_IDLE     = 8'b0000_0001,
        ST_FILL     = 8'b0000_0010,
        ST_MIX_RD   = 8'b0000_0100,
        ST_MIX_A    = 8'b0000_1000,
        ST_MIX_B    = 8'b0001_0000,
        ST_CIPH_LD  = 8'b0010_0000,
        ST_CIPH_RUN = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    opcode_t     op_reg, op_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [TI_W-1:0]   ti_reg, ti_next;
    logic [KI_W-1:0]   ki_reg, ki_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [31:0] fill_reg, fill_next;
    logic [31:0] kw_reg [KEY_WORDS];
    logic [31:0] kw_next [KEY_WORDS];
    logic        table_valid_reg, table_valid_next;

    logic [63:0] key_low_reg, key_high_reg;
    logic [31:0] magic_p_reg, magic_q_reg;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_a_reg, out_a_next;
    logic [31:0] out_b_reg, out_b_next;

    logic             we_even, we_odd;
    logic [ROW_W-1:0] waddr, rd_row;
    logic [31:0]      wdata_even, wdata_odd;
    logic [31:0]      rd_even, rd_odd, s_even, s_odd, s_cur;

    logic        req_accept;
    logic        slot_free;
    logic [31:0] enc_a, enc_b, dec_a, dec_b;
    logic [31:0] mix_a, mix_ab, mix_b;
    logic [TI_W-1:0]  ti_inc;
    logic [ROW_W-1:0] row_step;

    // ---------------- configuration registers ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            magic_p_reg  <= RESET_MAGIC_P;
            magic_q_reg  <= RESET_MAGIC_Q;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KEY_LOW:  key_low_reg  <= cfg.data;
                REG_KEY_HIGH: key_high_reg <= cfg.data;
                REG_MAGIC_P:  magic_p_reg  <= cfg.data[31:0];
                REG_MAGIC_Q:  magic_q_reg  <= cfg.data[31:0];
                default:      ;
            endcase
        end
    end

    // ---------------- round-key memories ----------------
    rc5_ram #(.WIDTH(32), .DEPTH(ROWS)) u_even_ram
    (
        .clk   (clk),
        .we    (we_even),
        .waddr (waddr),
        .wdata (wdata_even),
        .raddr (rd_row),
        .rdata (rd_even)
    );

    rc5_ram #(.WIDTH(32), .DEPTH(ROWS)) u_odd_ram
    (
        .clk   (clk),
        .we    (we_odd),
        .waddr (waddr),
        .wdata (wdata_odd),
        .raddr (rd_row),
        .rdata (rd_odd)
    );

    // Unwritten table reads as its reset value.
    assign s_even = table_valid_reg ? rd_even : '0;
    assign s_odd  = table_valid_reg ? rd_odd  : '0;
    assign s_cur  = ti_reg[0] ? s_odd : s_even;

    // ---------------- datapath ----------------
    assign enc_a = rotl32(a_reg ^ b_reg, b_reg[4:0]) + s_even;
    assign enc_b = rotl32(b_reg ^ enc_a, enc_a[4:0]) + s_odd;
    assign dec_b = rotr32(b_reg - s_odd, a_reg[4:0]) ^ a_reg;
    assign dec_a = rotr32(a_reg - s_even, dec_b[4:0]) ^ dec_b;

    assign mix_a  = rotl32(s_cur + a_reg + b_reg, 5'd3);
    assign mix_ab = a_reg + b_reg;
    assign mix_b  = rotl32(kw_reg[ki_reg] + mix_ab, mix_ab[4:0]);

    assign ti_inc   = (ti_reg == TI_W'(TABLE_WORDS - 1)) ? '0 : ti_reg + TI_W'(1);
    assign row_step = (op_reg == OP_ENCRYPT) ? row_reg + ROW_W'(1) : row_reg - ROW_W'(1);

    assign we_even    = (state_reg == ST_FILL) || ((state_reg == ST_MIX_A) && !ti_reg[0]);
    assign we_odd     = (state_reg == ST_FILL) || ((state_reg == ST_MIX_A) && ti_reg[0]);
    assign waddr      = (state_reg == ST_FILL) ? row_reg : ti_reg[TI_W-1:1];
    assign wdata_even = (state_reg == ST_FILL) ? fill_reg : mix_a;
    assign wdata_odd  = (state_reg == ST_FILL) ? fill_reg + magic_q_reg : mix_a;

    always_comb
    begin
        rd_row = row_reg;
        if (state_reg == ST_CIPH_RUN)
        begin
            rd_row = row_step;
        end
        else if (state_reg == ST_MIX_RD || state_reg == ST_MIX_B)
        begin
            rd_row = ti_reg[TI_W-1:1];
        end
    end

    // ---------------- handshake ----------------
    assign request.ready = (state_reg == ST_IDLE);
    assign req_accept    = request.valid && (state_reg == ST_IDLE);
    assign slot_free     = !out_valid_reg || result.ready;

    assign result.valid      = out_valid_reg;
    assign result.out_word_a = out_a_reg;
    assign result.out_word_b = out_b_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        row_next         = row_reg;
        ti_next          = ti_reg;
        ki_next          = ki_reg;
        step_next        = step_reg;
        fill_next        = fill_reg;
        kw_next          = kw_reg;
        table_valid_next = table_valid_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_a_next       = out_a_reg;
        out_b_next       = out_b_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    op_next = opcode_t'(request.opcode);
                    a_next  = request.in_word_a;
                    b_next  = request.in_word_b;
                    case (opcode_t'(request.opcode))
                        OP_ENCRYPT:
                        begin
                            row_next   = '0;
                            state_next = ST_CIPH_LD;
                        end
                        OP_DECRYPT:
                        begin
                            row_next   = ROW_W'(ROUNDS);
                            state_next = ST_CIPH_LD;
                        end
                        OP_EXPAND:
                        begin
                            a_next     = '0;
                            b_next     = '0;
                            row_next   = '0;
                            fill_next  = magic_p_reg;
                            kw_next[0] = key_low_reg[31:0];
                            kw_next[1] = key_low_reg[63:32];
                            kw_next[2] = key_high_reg[31:0];
                            kw_next[3] = key_high_reg[63:32];
                            state_next = ST_FILL;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_FILL:
            begin
                table_valid_next = 1'b1;
                fill_next        = fill_reg + {magic_q_reg[30:0], 1'b0};
                row_next         = row_reg + ROW_W'(1);
                if (row_reg == ROW_W'(ROWS - 1))
                begin
                    ti_next    = '0;
                    ki_next    = '0;
                    step_next  = '0;
                    state_next = ST_MIX_RD;
                end
            end

            ST_MIX_RD:
            begin
                state_next = ST_MIX_A;
            end

            ST_MIX_A:
            begin
                a_next     = mix_a;
                ti_next    = ti_inc;
                state_next = ST_MIX_B;
            end

            ST_MIX_B:
            begin
                b_next          = mix_b;
                kw_next[ki_reg] = mix_b;
                ki_next         = ki_reg + KI_W'(1);
                step_next       = step_reg + STEP_W'(1);
                state_next      = (step_reg == STEP_W'(MIX_STEPS - 1)) ? ST_DONE : ST_MIX_A;
            end

            ST_CIPH_LD:
            begin
                state_next = ST_CIPH_RUN;
            end

            ST_CIPH_RUN:
            begin
                row_next = row_step;
                if (op_reg == OP_ENCRYPT)
                begin
                    if (row_reg == '0)
                    begin
                        a_next = a_reg + s_even;
                        b_next = b_reg + s_odd;
                    end
                    else
                    begin
                        a_next = enc_a;
                        b_next = enc_b;
                    end
                    if (row_reg == ROW_W'(ROUNDS))
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    if (row_reg == '0)
                    begin
                        a_next     = a_reg - s_even;
                        b_next     = b_reg - s_odd;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        a_next = dec_a;
                        b_next = dec_b;
                    end
                end
            end

            ST_DONE:
            begin
                // hold until the result register is free
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (op_reg == OP_ENCRYPT || op_reg == OP_DECRYPT)
                    begin
                        out_a_next = a_reg;
                        out_b_next = b_reg;
                    end
                    else
                    begin
                        out_a_next = '0;
                        out_b_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            table_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            row_reg         <= '0;
            ti_reg          <= '0;
            ki_reg          <= '0;
            step_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            table_valid_reg <= table_valid_next;
            out_valid_reg   <= out_valid_next;
            row_reg         <= row_next;
            ti_reg          <= ti_next;
            ki_reg          <= ki_next;
            step_reg        <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        fill_reg  <= fill_next;
        kw_reg    <= kw_next;
        out_a_reg <= out_a_next;
        out_b_reg <= out_b_next;
    end

`ifndef SYNTHESIS
    a_table_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        table_valid_reg |=> table_valid_reg)
        else $error("round-key table valid flag dropped");

    a_no_table_write_in_cipher: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CIPH_LD || state_reg == ST_CIPH_RUN) |-> !(we_even || we_odd))
        else $error("round-key table written during a cipher request");

    a_mix_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX_A || state_reg == ST_MIX_B) |->
        (ti_reg < TI_W'(TABLE_WORDS)) && (step_reg < STEP_W'(MIX_STEPS)))
        else $error("key mixing index out of range");

    a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && slot_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished request did not reach the result register");
`endif

endmodule

/* sim/rc5_cipher_checker.sv */
`timescale 1ns / 1ps
// Checker for the RC5-32/12/16 block: watches the request, result and register channels,
// keeps its own round-key schedule and compares every result with the predicted block.
// Depends on rc5_pkg and the rc5 channel interfaces.
module rc5_cipher_checker
    import rc5_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rc5_req_if   request,
    rc5_res_if   result,
    rc5_cfg_if   cfg,
    output int   fail_count,
    output int   pending_count
);

    typedef struct packed
    {
        logic [31:0] word_a;
        logic [31:0] word_b;
    } block_t;

    logic [63:0] key_bytes_lo;
    logic [63:0] key_bytes_hi;
    logic [31:0] table_seed;
    logic [31:0] table_step;
    logic [31:0] key_sched [TABLE_WORDS];

    block_t pending_blocks [$];
    block_t want;

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input logic [31:0] n);
        logic [4:0] s;
        s = n[4:0];
        if (s == 5'd0)
            return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] rotate_right(input logic [31:0] x, input logic [31:0] n);
        logic [4:0] s;
        s = n[4:0];
        if (s == 5'd0)
            return x;
        return (x >> s) | (x << (32 - s));
    endfunction

    // Fill the schedule from seed and step, then run the standard mixing pass.
    function automatic void expand_schedule();
        logic [31:0] kw [KEY_WORDS];
        logic [31:0] a;
        logic [31:0] b;
        int          ti;
        int          ki;
        kw[0] = key_bytes_lo[31:0];
        kw[1] = key_bytes_lo[63:32];
        kw[2] = key_bytes_hi[31:0];
        kw[3] = key_bytes_hi[63:32];
        key_sched[0] = table_seed;
        for (int i = 1; i < TABLE_WORDS; i++)
            key_sched[i] = key_sched[i - 1] + table_step;
        a  = '0;
        b  = '0;
        ti = 0;
        ki = 0;
        for (int s = 0; s < MIX_STEPS; s++)
        begin
            a             = rotate_left(key_sched[ti] + a + b, 32'd3);
            key_sched[ti] = a;
            b             = rotate_left(kw[ki] + a + b, a + b);
            kw[ki]        = b;
            ti            = (ti + 1) % TABLE_WORDS;
            ki            = (ki + 1) % KEY_WORDS;
        end
    endfunction

    function automatic block_t compute_result_block(input opcode_t op, input logic [31:0] in_a,
                                                    input logic [31:0] in_b);
        block_t      res;
        logic [31:0] a;
        logic [31:0] b;
        a = in_a;
        b = in_b;
        case (op)
            OP_ENCRYPT:
            begin
                a = a + key_sched[0];
                b = b + key_sched[1];
                for (int i = 1; i <= ROUNDS; i++)
                begin
                    a = rotate_left(a ^ b, b) + key_sched[2 * i];
                    b = rotate_left(b ^ a, a) + key_sched[2 * i + 1];
                end
            end
            OP_DECRYPT:
            begin
                for (int i = ROUNDS; i > 0; i--)
                begin
                    b = rotate_right(b - key_sched[2 * i + 1], a) ^ a;
                    a = rotate_right(a - key_sched[2 * i], b) ^ b;
                end
                b = b - key_sched[1];
                a = a - key_sched[0];
            end
            OP_EXPAND:
            begin
                expand_schedule();
                a = '0;
                b = '0;
            end
            default:
            begin
                a = '0;
                b = '0;
            end
        endcase
        res.word_a = a;
        res.word_b = b;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        fail_count++;
        $display("%0t mismatch: %s got %08h wanted %08h", $realtime, what, got, wanted);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_lo = '0;
            key_bytes_hi = '0;
            table_seed   = RESET_MAGIC_P;
            table_step   = RESET_MAGIC_Q;
            for (int i = 0; i < TABLE_WORDS; i++)
                key_sched[i] = '0;
            pending_blocks.delete();
            pending_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_KEY_LOW:  key_bytes_lo = cfg.data;
                    REG_KEY_HIGH: key_bytes_hi = cfg.data;
                    REG_MAGIC_P:  table_seed   = cfg.data[31:0];
                    REG_MAGIC_Q:  table_step   = cfg.data[31:0];
                    default: ;
                endcase
            end
            // A result at this edge can only belong to a request taken at an earlier edge.
            if (result.valid && result.ready)
            begin
                if (pending_blocks.size() == 0)
                    report_mismatch("result with no request waiting, word_a",
                                    result.out_word_a, 32'd0);
                else
                begin
                    want = pending_blocks.pop_front();
                    if (result.out_word_a !== want.word_a)
                        report_mismatch("out_word_a", result.out_word_a, want.word_a);
                    if (result.out_word_b !== want.word_b)
                        report_mismatch("out_word_b", result.out_word_b, want.word_b);
                end
            end
            if (request.valid && request.ready)
                pending_blocks.push_back(compute_result_block(opcode_t'(request.opcode),
                                                              request.in_word_a,
                                                              request.in_word_b));
            pending_count = pending_blocks.size();
        end
    end

endmodule

/* sim/tb_rc5_block_cipher.sv */
`timescale 1ns / 1ps
// Top of the RC5-32/12/16 block test: clock, reset, register writes, block requests and
// result back-pressure. Depends on rc5_pkg, the rc5 interfaces, the block and the checker.
module tb_rc5_block_cipher;
    import rc5_pkg::*;

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   fail_count;
    int   pending_count;

    rc5_req_if request_if();
    rc5_res_if result_if();
    rc5_cfg_if cfg_if();

    rc5_block_cipher dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    rc5_cipher_checker u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request_if),
        .result       (result_if),
        .cfg          (cfg_if),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 32'h0000_0000;
        if (r < 16)
            return 32'hffff_ffff;
        if (r < 24)
            return $urandom() & 32'hffff_ffe0;   // rotate amount of zero
        return $urandom();
    endfunction

    task automatic send_request(input opcode_t op, input logic [31:0] a, input logic [31:0] b);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            request_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_if.valid     <= 1'b1;
        request_if.opcode    <= op;
        request_if.in_word_a <= a;
        request_if.in_word_b <= b;
        do
            @(posedge clk);
        while (!request_if.ready);
    endtask

    // Hold off requests until every result has come back.
    task automatic drain_results();
        request_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all_regs(input logic [63:0] klo, input logic [63:0] khi,
                                  input logic [31:0] p, input logic [31:0] q);
        write_reg(REG_KEY_LOW, klo);
        write_reg(REG_KEY_HIGH, khi);
        write_reg(REG_MAGIC_P, {32'd0, p});
        write_reg(REG_MAGIC_Q, {32'd0, q});
    endtask

    // Result side: ready in runs, broken by random stalls.
    initial
    begin
        int run;
        int stall;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run = $urandom_range(8, 1);
            result_if.ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = idle_len();
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        int      r;
        opcode_t op;
        no_idle              = 1'b0;
        rst_n                <= 1'b0;
        request_if.valid     <= 1'b0;
        request_if.opcode    <= OP_ENCRYPT;
        request_if.in_word_a <= '0;
        request_if.in_word_b <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= REG_KEY_LOW;
        cfg_if.data          <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Cipher on the all-zero table left by reset, and the unused opcode.
        send_request(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_DECRYPT, 32'h1234_5678, 32'h9abc_def0);
        send_request(OP_DECRYPT, 32'hffff_ffff, 32'h0000_0000);
        send_request(OP_NONE, 32'hffff_ffff, 32'hffff_ffff);

        // Expansion with the reset constants and a zero key.
        send_request(OP_EXPAND, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_ENCRYPT, 32'h0000_0000, 32'hffff_ffff);
        send_request(OP_DECRYPT, 32'hffff_ffff, 32'h0000_0000);
        send_request(OP_ENCRYPT, 32'h0000_0040, 32'h0000_0020);
        send_request(OP_DECRYPT, 32'h8000_0000, 32'h0000_0000);
        // The unused opcode must leave the schedule alone.
        send_request(OP_NONE, 32'h5a5a_5a5a, 32'ha5a5_a5a5);
        send_request(OP_ENCRYPT, 32'h0000_0040, 32'h0000_0020);
        drain_results();

        write_all_regs(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                       32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_EXPAND, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_ENCRYPT, 32'hdead_beef, 32'h0000_0000);
        drain_results();

        for (int phase = 0; phase < 8; phase++)
        begin
            no_idle = (phase == 3 || phase == 6);
            drain_results();
            case (phase)
                0: write_all_regs(64'd0, 64'd0, 32'd0, 32'd0);
                1: write_all_regs({$urandom(), $urandom()}, {$urandom(), $urandom()},
                                  32'hffff_ffff, 32'h0000_0000);
                2: write_all_regs({$urandom(), $urandom()}, {$urandom(), $urandom()},
                                  32'hb7e1_5163, 32'h9e37_79b9);
                3: write_all_regs({$urandom(), $urandom()}, {$urandom(), $urandom()},
                                  RESET_MAGIC_P, RESET_MAGIC_Q);
                default: write_all_regs({$urandom(), $urandom()}, {$urandom(), $urandom()},
                                        $urandom(), $urandom());
            endcase
            send_request(OP_EXPAND, rand_word(), rand_word());
            for (int n = 0; n < 85; n++)
            begin
                r = $urandom_range(99);
                if (r < 2)
                begin
                    // Pause until the block is empty, then change one register.
                    drain_results();
                    write_reg(reg_index_t'($urandom_range(3)), {$urandom(), $urandom()});
                end
                r = $urandom_range(99);
                if (r < 45)
                    op = OP_ENCRYPT;
                else if (r < 90)
                    op = OP_DECRYPT;
                else if (r < 95)
                    op = OP_NONE;
                else
                    op = OP_EXPAND;
                send_request(op, rand_word(), rand_word());
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* rc5_block_cipher.f */
rtl/rc5_pkg.sv
rtl/rc5_if.sv
rtl/rc5_ram.sv
rtl/rc5_block_cipher.sv
sim/rc5_cipher_checker.sv
sim/tb_rc5_block_cipher.sv
